>>> rtl/core/dlsc_pkg.sv
// ----------------------------------------------------------------------------
// dlsc_pkg
// Types, state codes and request codes shared by the link state controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dlsc_pkg;

  // Status encoding, as seen on the PHY status and reported link state
  localparam logic [3:0] StsReset     = 4'd0;
  localparam logic [3:0] StsActive    = 4'd1;
  localparam logic [3:0] StsLinkReset = 4'd9;
  localparam logic [3:0] StsLinkError = 4'd10;
  localparam logic [3:0] StsRetrain   = 4'd11;
  localparam logic [3:0] StsDisabled  = 4'd12;

  // Request encoding, towards the PHY and from the protocol layer
  localparam logic [3:0] ReqNop       = 4'd0;
  localparam logic [3:0] ReqActive    = 4'd1;
  localparam logic [3:0] ReqLinkReset = 4'd9;
  localparam logic [3:0] ReqRetrain   = 4'd11;
  localparam logic [3:0] ReqDisabled  = 4'd12;

  // Link state, one-hot
  typedef enum logic [5:0] {
    LS_RESET     = 6'b000001,
    LS_ACTIVE    = 6'b000010,
    LS_RETRAIN   = 6'b000100,
    LS_LINKERROR = 6'b001000,
    LS_DISABLED  = 6'b010000,
    LS_LINKRESET = 6'b100000
  } link_state_e;

  // One sampled set of interface signals
  typedef struct packed {
    logic [3:0] proto_state_req;
    logic       proto_link_error;
    logic [3:0] phy_state_status;
    logic       proto_rx_active_status;
    logic       stall_done;
    logic       dis_entry;
    logic       reset_entry;
    logic       act_entry;
    logic       init_rx_active_req;
    logic       init_inband_present;
    logic [3:0] init_phy_state_req;
  } dlsc_item_t;

  // Controller registers, which are also the result of a request
  typedef struct packed {
    link_state_e state;
    logic [3:0]  phy_req;
    logic        link_err;
    logic        rx_req;
    logic        inband;
    logic        stall;
  } dlsc_regs_t;

  // Map the one-hot state to its status code
  function automatic logic [3:0] state_code(link_state_e s);
    logic [3:0] code;
    case (s)
      LS_RESET:     code = StsReset;
      LS_ACTIVE:    code = StsActive;
      LS_RETRAIN:   code = StsRetrain;
      LS_LINKERROR: code = StsLinkError;
      LS_DISABLED:  code = StsDisabled;
      LS_LINKRESET: code = StsLinkReset;
      default:      code = StsReset;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/dlsc_next_state.sv
// ----------------------------------------------------------------------------
// dlsc_next_state
// Next-state and next-output logic of the link state controller for one
// sampled request.
// ----------------------------------------------------------------------------
`default_nettype none

module dlsc_next_state
  import dlsc_pkg::*;
(
  input  dlsc_item_t item_i,
  input  dlsc_regs_t cur_i,
  output dlsc_regs_t nxt_o
);

  logic phy_err;
  logic phy_rtr;
  logic phy_rst;
  logic rx_quiet;
  logic hs_done;
  logic req_act;
  logic dis_e;
  logic rst_e;

  // Decode status and handshake conditions
  assign phy_err  = (item_i.phy_state_status == StsLinkError);
  assign phy_rtr  = (item_i.phy_state_status == StsRetrain);
  assign phy_rst  = (item_i.phy_state_status == StsReset);
  assign rx_quiet = !item_i.proto_rx_active_status && !cur_i.rx_req;
  assign hs_done  = cur_i.stall && item_i.stall_done;
  assign req_act  = (item_i.proto_state_req == ReqActive);
  assign dis_e    = item_i.dis_entry;
  assign rst_e    = item_i.reset_entry;

  always_comb begin
    nxt_o          = cur_i;
    nxt_o.link_err = item_i.proto_link_error;

    // Stall request: raise only from Active on a pending exit
    nxt_o.stall = (cur_i.state == LS_ACTIVE) && (rst_e || dis_e || phy_rtr);

    // Rx-active request
    if (cur_i.state == LS_ACTIVE) begin
      nxt_o.rx_req = !(rst_e || dis_e || phy_rtr || phy_err);
    end else begin
      nxt_o.rx_req = (rst_e || dis_e || phy_err) ? 1'b0 : item_i.init_rx_active_req;
    end

    // In-band presence
    if (cur_i.state == LS_RESET) begin
      nxt_o.inband = phy_err ? 1'b0 : item_i.init_inband_present;
    end else if (cur_i.state == LS_LINKERROR || cur_i.state == LS_DISABLED ||
                 cur_i.state == LS_LINKRESET) begin
      nxt_o.inband = 1'b0;
    end else begin
      nxt_o.inband = !phy_err;
    end

    // State transitions and PHY request
    case (cur_i.state)
      LS_RESET: begin
        nxt_o.phy_req = item_i.init_phy_state_req;
        if (phy_err) begin
          nxt_o.state = LS_LINKERROR;
        end else if (dis_e && rx_quiet) begin
          nxt_o.state = LS_DISABLED;
        end else if (rst_e && rx_quiet) begin
          nxt_o.state = LS_LINKRESET;
        end else if (item_i.act_entry) begin
          nxt_o.state = LS_ACTIVE;
        end
      end
      LS_ACTIVE: begin
        if (phy_rtr) begin
          nxt_o.phy_req = ReqRetrain;
        end
        if (phy_err) begin
          nxt_o.state = LS_LINKERROR;
        end else if (dis_e && rx_quiet && hs_done) begin
          nxt_o.state = LS_DISABLED;
        end else if (rst_e && rx_quiet && hs_done) begin
          nxt_o.state = LS_LINKRESET;
        end else if (phy_rtr && rx_quiet && hs_done) begin
          nxt_o.state = LS_RETRAIN;
        end
      end
      LS_RETRAIN: begin
        nxt_o.phy_req = ReqNop;
        if (phy_err) begin
          nxt_o.state = LS_LINKERROR;
        end else if (dis_e) begin
          nxt_o.state = LS_DISABLED;
        end else if (rst_e) begin
          nxt_o.state = LS_LINKRESET;
        end
      end
      LS_LINKERROR: begin
        nxt_o.phy_req = (req_act && phy_err) ? ReqActive : ReqNop;
        if ((req_act || phy_err) && rx_quiet) begin
          nxt_o.state = LS_RESET;
        end
      end
      LS_DISABLED: begin
        nxt_o.phy_req = req_act ? ReqActive : ReqDisabled;
        if (phy_err) begin
          nxt_o.state = LS_LINKERROR;
        end else if (req_act || phy_rst) begin
          nxt_o.state = LS_RESET;
        end
      end
      LS_LINKRESET: begin
        nxt_o.phy_req = req_act ? ReqActive : ReqLinkReset;
        if (phy_err) begin
          nxt_o.state = LS_LINKERROR;
        end else if (dis_e && rx_quiet) begin
          nxt_o.state = LS_DISABLED;
        end else if (req_act || phy_rst) begin
          nxt_o.state = LS_RESET;
        end
      end
      default: begin
        nxt_o.state = cur_i.state;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/die_link_state_controller_core.sv
// Path: a request is held in the input register, then the controller registers
// form its result and present it on the outputs.
// Throughput: one request per cycle while results are taken; the state update
// is a single pass of next-state logic from input to controller registers.
// Reset: asynchronous, active low; link state goes to Reset, PHY request to
// Nop, all other result outputs to zero, and both pipeline stages are emptied.
// ----------------------------------------------------------------------------
// die_link_state_controller_core
// Die-to-die adapter link state machine with a valid/ready request stream.
// ----------------------------------------------------------------------------
`default_nettype none

module die_link_state_controller_core
  import dlsc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,

  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [3:0] proto_state_req_i,
  input  wire logic       proto_link_error_i,
  input  wire logic [3:0] phy_state_status_i,
  input  wire logic       proto_rx_active_status_i,
  input  wire logic       stall_done_i,
  input  wire logic       disabled_entry_i,
  input  wire logic       reset_entry_i,
  input  wire logic       active_entry_i,
  input  wire logic       init_rx_active_req_i,
  input  wire logic       init_inband_present_i,
  input  wire logic [3:0] init_phy_state_req_i,

  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [3:0]      link_state_out_o,
  output logic [3:0]      phy_state_req_out_o,
  output logic            phy_link_error_out_o,
  output logic            rx_active_req_out_o,
  output logic            inband_present_out_o,
  output logic            stall_req_out_o
);

  dlsc_item_t item_q;
  logic       item_valid_q;
  dlsc_regs_t regs_q;
  dlsc_regs_t regs_d;
  logic       out_valid_q;
  logic       advance;

  // Move a request on when the result slot is free or being drained
  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  // Hold the sampled request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.proto_state_req        <= proto_state_req_i;
      item_q.proto_link_error       <= proto_link_error_i;
      item_q.phy_state_status       <= phy_state_status_i;
      item_q.proto_rx_active_status <= proto_rx_active_status_i;
      item_q.stall_done             <= stall_done_i;
      item_q.dis_entry              <= disabled_entry_i;
      item_q.reset_entry            <= reset_entry_i;
      item_q.act_entry              <= active_entry_i;
      item_q.init_rx_active_req     <= init_rx_active_req_i;
      item_q.init_inband_present    <= init_inband_present_i;
      item_q.init_phy_state_req     <= init_phy_state_req_i;
    end
  end

  dlsc_next_state u_next_state (
    .item_i (item_q),
    .cur_i  (regs_q),
    .nxt_o  (regs_d)
  );

  // Advance the controller registers, which double as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.state     <= LS_RESET;
      regs_q.phy_req   <= ReqNop;
      regs_q.link_err  <= 1'b0;
      regs_q.rx_req    <= 1'b0;
      regs_q.inband    <= 1'b0;
      regs_q.stall     <= 1'b0;
    end else if (advance) begin
      regs_q <= regs_d;
    end
  end

  // Result valid: set on advance, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign link_state_out_o     = state_code(regs_q.state);
  assign phy_state_req_out_o  = regs_q.phy_req;
  assign phy_link_error_out_o = regs_q.link_err;
  assign rx_active_req_out_o  = regs_q.rx_req;
  assign inband_present_out_o = regs_q.inband;
  assign stall_req_out_o      = regs_q.stall;

endmodule

`default_nettype wire

>>> verif/die_link_state_controller_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// die_link_state_controller_core_tb
// Streams requests through the link state controller and checks every result
// against a cycle model of the state machine held in the bench. A directed
// walk visits every link state and the unknown codes. A drain pause and an
// unbroken stream follow, then long runs of state-steered random requests
// with random idling on both sides.
// ----------------------------------------------------------------------------
module die_link_state_controller_core_tb;
  import dlsc_pkg::*;

  // Longest run of cycles with no handshake on either side
  localparam int unsigned IdleLimit = 2000;

  // Controller registers in status encoding, as they appear on the outputs
  typedef struct packed {
    logic [3:0] state;
    logic [3:0] phy_req;
    logic       link_err;
    logic       rx_req;
    logic       inband;
    logic       stall;
  } link_regs_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [3:0] proto_state_req_i = '0;
  logic       proto_link_error_i = 1'b0;
  logic [3:0] phy_state_status_i = '0;
  logic       proto_rx_active_status_i = 1'b0;
  logic       stall_done_i = 1'b0;
  logic       disabled_entry_i = 1'b0;
  logic       reset_entry_i = 1'b0;
  logic       active_entry_i = 1'b0;
  logic       init_rx_active_req_i = 1'b0;
  logic       init_inband_present_i = 1'b0;
  logic [3:0] init_phy_state_req_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [3:0] link_state_out_o;
  logic [3:0] phy_state_req_out_o;
  logic       phy_link_error_out_o;
  logic       rx_active_req_out_o;
  logic       inband_present_out_o;
  logic       stall_req_out_o;

  link_regs_t  model_regs;
  link_regs_t  pending_regs[$];
  int unsigned err_cnt = 0;
  int unsigned idle_run = 0;
  int unsigned sink_hold = 0;
  bit          sink_stalls = 1'b1;

  die_link_state_controller_core u_top (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .in_valid_i               (in_valid_i),
    .in_ready_o               (in_ready_o),
    .proto_state_req_i        (proto_state_req_i),
    .proto_link_error_i       (proto_link_error_i),
    .phy_state_status_i       (phy_state_status_i),
    .proto_rx_active_status_i (proto_rx_active_status_i),
    .stall_done_i             (stall_done_i),
    .disabled_entry_i         (disabled_entry_i),
    .reset_entry_i            (reset_entry_i),
    .active_entry_i           (active_entry_i),
    .init_rx_active_req_i     (init_rx_active_req_i),
    .init_inband_present_i    (init_inband_present_i),
    .init_phy_state_req_i     (init_phy_state_req_i),
    .out_valid_o              (out_valid_o),
    .out_ready_i              (out_ready_i),
    .link_state_out_o         (link_state_out_o),
    .phy_state_req_out_o      (phy_state_req_out_o),
    .phy_link_error_out_o     (phy_link_error_out_o),
    .rx_active_req_out_o      (rx_active_req_out_o),
    .inband_present_out_o     (inband_present_out_o),
    .stall_req_out_o          (stall_req_out_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Cycle model of the controller
  // --------------------------------------------------------------------------

  // Advance the registers by one request; decisions use the old values
  function automatic link_regs_t next_link_regs(link_regs_t r, dlsc_item_t it);
    link_regs_t n;
    logic       phy_err;
    logic       phy_rtr;
    logic       rx_quiet;
    logic       hs_done;
    logic       req_act;
    logic       leave;
    phy_err  = (it.phy_state_status == StsLinkError);
    phy_rtr  = (it.phy_state_status == StsRetrain);
    rx_quiet = !it.proto_rx_active_status && !r.rx_req;
    hs_done  = r.stall && it.stall_done;
    req_act  = (it.proto_state_req == ReqActive);
    leave    = it.reset_entry || it.dis_entry;
    n = r;
    n.link_err = it.proto_link_error;
    n.stall = (r.state == StsActive) && (leave || phy_rtr);
    if (r.state == StsActive) begin
      n.rx_req = !(leave || phy_rtr || phy_err);
    end else begin
      n.rx_req = (leave || phy_err) ? 1'b0 : it.init_rx_active_req;
    end
    case (r.state)
      StsReset: n.inband = !phy_err && it.init_inband_present;
      StsLinkError, StsDisabled, StsLinkReset: n.inband = 1'b0;
      default: n.inband = !phy_err;
    endcase
    case (r.state)
      StsReset: begin
        n.phy_req = it.init_phy_state_req;
        if (phy_err) n.state = StsLinkError;
        else if (it.dis_entry && rx_quiet) n.state = StsDisabled;
        else if (it.reset_entry && rx_quiet) n.state = StsLinkReset;
        else if (it.act_entry) n.state = StsActive;
      end
      StsActive: begin
        // hold the PHY request unless the PHY reports retrain
        if (phy_rtr) n.phy_req = ReqRetrain;
        if (phy_err) n.state = StsLinkError;
        else if (it.dis_entry && rx_quiet && hs_done) n.state = StsDisabled;
        else if (it.reset_entry && rx_quiet && hs_done) n.state = StsLinkReset;
        else if (phy_rtr && rx_quiet && hs_done) n.state = StsRetrain;
      end
      StsRetrain: begin
        n.phy_req = ReqNop;
        if (phy_err) n.state = StsLinkError;
        else if (it.dis_entry) n.state = StsDisabled;
        else if (it.reset_entry) n.state = StsLinkReset;
      end
      StsLinkError: begin
        n.phy_req = (req_act && phy_err) ? ReqActive : ReqNop;
        if ((req_act || phy_err) && rx_quiet) n.state = StsReset;
      end
      StsDisabled: begin
        n.phy_req = req_act ? ReqActive : ReqDisabled;
        if (phy_err) n.state = StsLinkError;
        else if (req_act || it.phy_state_status == StsReset) n.state = StsReset;
      end
      StsLinkReset: begin
        n.phy_req = req_act ? ReqActive : ReqLinkReset;
        if (phy_err) n.state = StsLinkError;
        else if (it.dis_entry && rx_quiet) n.state = StsDisabled;
        else if (req_act || it.phy_state_status == StsReset) n.state = StsReset;
      end
      default: ;
    endcase
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------

  function automatic bit chance(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(24, 4);
  endfunction

  function automatic logic [3:0] pick_status(int unsigned err_pct);
    if (chance(err_pct)) return StsLinkError;
    case ($urandom_range(5))
      0: return StsReset;
      1: return StsActive;
      2: return StsRetrain;
      3: return StsDisabled;
      4: return StsLinkReset;
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  function automatic logic [3:0] pick_request(int unsigned act_pct);
    if (chance(act_pct)) return ReqActive;
    case ($urandom_range(4))
      0: return ReqNop;
      1: return ReqRetrain;
      2: return ReqDisabled;
      3: return ReqLinkReset;
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  // Build a request that tends to move the link on from its current state;
  // a share stays pure noise
  function automatic dlsc_item_t steer_item(link_regs_t r);
    dlsc_item_t  it;
    logic [31:0] raw;
    int unsigned err_pct;
    int unsigned act_pct;
    int unsigned rtr_pct;
    int unsigned leave_pct;
    raw = $urandom;
    it = raw[$bits(dlsc_item_t)-1:0];
    if (chance(15)) return it;
    err_pct   = 5;
    act_pct   = 20;
    rtr_pct   = 0;
    leave_pct = 12;
    case (r.state)
      StsActive: begin
        rtr_pct = 30;
        err_pct = 3;
      end
      StsRetrain: leave_pct = 25;
      StsLinkError: begin
        err_pct = 40;
        act_pct = 40;
      end
      StsDisabled, StsLinkReset: act_pct = 25;
      default: ;
    endcase
    it.phy_state_status       = chance(rtr_pct) ? StsRetrain : pick_status(err_pct);
    it.proto_state_req        = pick_request(act_pct);
    it.proto_rx_active_status = chance(25);
    it.stall_done             = r.stall ? chance(80) : chance(40);
    it.dis_entry              = chance(leave_pct);
    it.reset_entry            = chance(leave_pct);
    it.act_entry              = chance(r.state == StsReset ? 35 : 15);
    return it;
  endfunction

  function automatic dlsc_item_t walk_item(
    logic [3:0] preq, logic perr, logic [3:0] phy, logic rx_sts, logic sdone,
    logic dis_e, logic rst_e, logic act_e, logic init_rx, logic init_inb,
    logic [3:0] init_req
  );
    dlsc_item_t it;
    it.proto_state_req        = preq;
    it.proto_link_error       = perr;
    it.phy_state_status       = phy;
    it.proto_rx_active_status = rx_sts;
    it.stall_done             = sdone;
    it.dis_entry              = dis_e;
    it.reset_entry            = rst_e;
    it.act_entry              = act_e;
    it.init_rx_active_req     = init_rx;
    it.init_inband_present    = init_inb;
    it.init_phy_state_req     = init_req;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Drop valid while the request side idles
  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Present one request, hold it until accepted, then predict its result
  task automatic send_req(input dlsc_item_t it);
    @(negedge clk_i);
    in_valid_i               <= 1'b1;
    proto_state_req_i        <= it.proto_state_req;
    proto_link_error_i       <= it.proto_link_error;
    phy_state_status_i       <= it.phy_state_status;
    proto_rx_active_status_i <= it.proto_rx_active_status;
    stall_done_i             <= it.stall_done;
    disabled_entry_i         <= it.dis_entry;
    reset_entry_i            <= it.reset_entry;
    active_entry_i           <= it.act_entry;
    init_rx_active_req_i     <= it.init_rx_active_req;
    init_inband_present_i    <= it.init_inband_present;
    init_phy_state_req_i     <= it.init_phy_state_req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    model_regs = next_link_regs(model_regs, it);
    pending_regs.push_back(model_regs);
  endtask

  task automatic wait_results_drained();
    idle_cycles(1);
    while (pending_regs.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Walk every link state, with unknown codes and all-ones fields on the way
  task automatic test_state_walk();
    dlsc_item_t walk[$];
    // order: proto req, proto err, phy status, rx status, stall done,
    //        disabled entry, reset entry, active entry, init rx, init inband,
    //        init phy req
    walk.push_back(walk_item(ReqNop, 0, StsReset, 0, 0, 0, 0, 0, 0, 0, ReqNop));
    walk.push_back(walk_item(4'hF, 1, 4'hF, 1, 1, 0, 0, 0, 1, 1, 4'hF));
    walk.push_back(walk_item(ReqNop, 0, StsActive, 1, 0, 0, 0, 1, 1, 1, ReqActive));
    walk.push_back(walk_item(ReqNop, 1, StsActive, 1, 0, 0, 0, 0, 0, 0, ReqNop));
    // disable while rx still active: stall raised, no move yet
    walk.push_back(walk_item(ReqNop, 0, StsActive, 0, 1, 1, 0, 0, 0, 0, ReqNop));
    walk.push_back(walk_item(ReqNop, 0, StsActive, 0, 1, 1, 0, 0, 0, 0, ReqNop));
    walk.push_back(walk_item(ReqNop, 0, StsDisabled, 0, 0, 0, 0, 0, 0, 0, ReqNop));
    walk.push_back(walk_item(ReqNop, 0, StsReset, 0, 0, 0, 0, 0, 0, 0, ReqNop));
    walk.push_back(walk_item(ReqNop, 0, StsReset, 0, 0, 0, 1, 0, 0, 0, ReqNop));
    walk.push_back(walk_item(ReqNop, 0, StsLinkReset, 0, 0, 1, 0, 0, 0, 0, ReqNop));
    walk.push_back(walk_item(ReqActive, 0, StsDisabled, 0, 0, 0, 0, 0, 0, 0, ReqNop));
    walk.push_back(walk_item(ReqNop, 0, StsReset, 0, 0, 0, 0, 1, 0, 1, ReqActive));
    // retrain takes a stall handshake first
    walk.push_back(walk_item(ReqNop, 0, StsRetrain, 0, 0, 0, 0, 0, 0, 0, ReqNop));
    walk.push_back(walk_item(ReqNop, 0, StsRetrain, 0, 1, 0, 0, 0, 0, 0, ReqNop));
    walk.push_back(walk_item(ReqNop, 0, StsRetrain, 0, 0, 0, 1, 0, 0, 0, ReqNop));
    walk.push_back(walk_item(ReqNop, 0, StsLinkError, 0, 0, 0, 0, 0, 0, 0, ReqNop));
    // link error held while rx reports active
    walk.push_back(walk_item(ReqActive, 0, StsLinkError, 1, 0, 0, 0, 0, 1, 0, ReqNop));
    walk.push_back(walk_item(ReqNop, 0, StsLinkError, 0, 0, 0, 0, 0, 0, 0, ReqNop));
    walk.push_back(walk_item(ReqNop, 0, StsReset, 0, 0, 0, 0, 1, 1, 1, ReqNop));
    walk.push_back(walk_item(ReqNop, 0, StsRetrain, 0, 0, 0, 0, 0, 0, 0, ReqNop));
    walk.push_back(walk_item(ReqNop, 0, StsRetrain, 0, 1, 0, 0, 0, 0, 0, ReqNop));
    walk.push_back(walk_item(ReqNop, 0, StsLinkError, 0, 0, 1, 0, 0, 0, 0, ReqNop));
    walk.push_back(walk_item(ReqActive, 0, StsActive, 0, 0, 0, 0, 0, 0, 0, ReqNop));
    walk.push_back(walk_item(ReqNop, 0, StsLinkError, 0, 0, 0, 0, 1, 1, 1, 4'hF));
    foreach (walk[i]) begin
      idle_cycles(gap_len());
      send_req(walk[i]);
    end
  endtask

  // Hold the sender off until every result is back, a few times over
  task automatic test_drain_pause();
    repeat (3) begin
      repeat (20) begin
        idle_cycles(gap_len());
        send_req(steer_item(model_regs));
      end
      wait_results_drained();
    end
  endtask

  // Back-to-back requests with no new random stalls on the result side
  task automatic test_streaming(input int unsigned n);
    sink_stalls = 1'b0;
    repeat (n) send_req(steer_item(model_regs));
    sink_stalls = 1'b1;
  endtask

  // Random requests with idling on both sides
  task automatic test_random_traffic(input int unsigned n);
    repeat (n) begin
      idle_cycles(gap_len());
      send_req(steer_item(model_regs));
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // Stall the result side at random
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold--;
      out_ready_i <= 1'b0;
    end else if (!sink_stalls || chance(70)) begin
      out_ready_i <= 1'b1;
    end else begin
      sink_hold = gap_len();
      out_ready_i <= 1'b0;
    end
  end

  function automatic void report_field(string name, logic [3:0] want, logic [3:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    link_regs_t want;
    link_regs_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {link_state_out_o, phy_state_req_out_o, phy_link_error_out_o,
             rx_active_req_out_o, inband_present_out_o, stall_req_out_o};
      if (pending_regs.size() == 0) begin
        $display("%0t: result with no request pending: expected none, actual %h",
                 $time, got);
        err_cnt++;
      end else begin
        want = pending_regs.pop_front();
        if (want !== got) begin
          err_cnt++;
          report_field("link state", want.state, got.state);
          report_field("phy_state_req", want.phy_req, got.phy_req);
          report_field("phy_link_error", 4'(want.link_err), 4'(got.link_err));
          report_field("rx_active_req", 4'(want.rx_req), 4'(got.rx_req));
          report_field("inband_present", 4'(want.inband), 4'(got.inband));
          report_field("stall_req", 4'(want.stall), 4'(got.stall));
        end
      end
    end
  end

  // Drop the run if no handshake happens for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_run = 0;
    end else begin
      idle_run++;
    end
    if (idle_run >= IdleLimit) begin
      $display("die_link_state_controller_core test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    model_regs = '{state: StsReset, phy_req: ReqNop, default: 1'b0};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_state_walk();
    test_drain_pause();
    test_streaming(300);
    test_random_traffic(1050);
    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("die_link_state_controller_core test passed");
    end else begin
      $display("die_link_state_controller_core test failed");
    end
    $finish;
  end

endmodule
